// ----- hw/rtl/zigzag_varint_decoder_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the zigzag varint decoder
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ZIGZAG_VARINT_DECODER_UNIT_DEFINES_SVH
`define ZIGZAG_VARINT_DECODER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define ZVD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ZVD_ASSERT_NEVER(lbl, cond, msg) \
  `ZVD_ASSERT(lbl, !(cond), msg)
`else
`define ZVD_ASSERT(lbl, prop, msg)
`define ZVD_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ----- hw/rtl/zvd_pkg.sv -----
// ----------------------------------------------------------------------------
// Zigzag varint decoder package
// Field widths, width codes, per-width tables and shared stage types.
// ----------------------------------------------------------------------------
package zvd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned GroupW  = 7;
  localparam int unsigned WcodeW  = 2;
  localparam int unsigned ValueW  = 64;
  localparam int unsigned CountW  = 4;
  localparam int unsigned ShiftW  = 6;

  localparam logic [GroupW-1:0] DataMask = 7'b1111111;
  localparam logic [ByteW-1:0]  ContMask = 8'b10000000;

  typedef enum logic [WcodeW-1:0] {
    W8  = 2'd0,
    W16 = 2'd1,
    W32 = 2'd2,
    W64 = 2'd3
  } width_e;

  typedef struct packed {
    logic [ByteW-1:0]  data_byte;
    logic [WcodeW-1:0] width_code;
  } beat_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              too_long;
    logic [CountW-1:0] byte_count;
  } result_t;

  typedef struct packed {
    logic    produce;
    result_t res;
  } dec_out_t;

  function automatic logic [CountW-1:0] last_index(input width_e wc);
    logic [CountW-1:0] r;
    case (wc)
      W8:      r = 4'd1;
      W16:     r = 4'd2;
      W32:     r = 4'd4;
      W64:     r = 4'd9;
      default: r = 4'd9;
    endcase
    return r;
  endfunction

  function automatic logic [GroupW-1:0] excess_mask(input width_e wc);
    logic [GroupW-1:0] r;
    case (wc)
      W8:      r = 7'h7E;
      W16:     r = 7'h7C;
      W32:     r = 7'h70;
      W64:     r = 7'h7E;
      default: r = 7'h7E;
    endcase
    return r;
  endfunction

  function automatic logic [ValueW-1:0] width_mask(input width_e wc);
    logic [ValueW-1:0] r;
    case (wc)
      W8:      r = 64'h0000_0000_0000_00FF;
      W16:     r = 64'h0000_0000_0000_FFFF;
      W32:     r = 64'h0000_0000_FFFF_FFFF;
      W64:     r = 64'hFFFF_FFFF_FFFF_FFFF;
      default: r = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/zvd_in_if.sv -----
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying one encoded byte and a width code per beat.
// ----------------------------------------------------------------------------
interface zvd_in_if import zvd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  data_byte;
  logic [WcodeW-1:0] width_code;

  modport source (output valid, output data_byte, output width_code, input ready);
  modport sink   (input valid, input data_byte, input width_code, output ready);
endinterface

// ----- hw/rtl/zvd_out_if.sv -----
// ----------------------------------------------------------------------------
// Output channel
// Valid/ready channel carrying one decoded value or error per beat.
// ----------------------------------------------------------------------------
interface zvd_out_if import zvd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;
  logic              too_long;
  logic [CountW-1:0] byte_count;

  modport source (output valid, output value, output too_long, output byte_count,
                  input ready);
  modport sink   (input valid, input value, input too_long, input byte_count,
                  output ready);
endinterface

// ----- hw/rtl/zvd_in_reg.sv -----
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted beat until the decode stage consumes it.
// ----------------------------------------------------------------------------
module zvd_in_reg import zvd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  beat_t beat_i,
  input  logic  advance_i,
  output logic  valid_o,
  output beat_t beat_o
);

  logic  valid_q, valid_d;
  beat_t beat_q, beat_d;

  assign ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    beat_d  = beat_q;
    if (ready_o) begin
      valid_d = valid_i;
      if (valid_i) begin
        beat_d = beat_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// ----- hw/rtl/zvd_decode.sv -----
// ----------------------------------------------------------------------------
// Decode stage
// Gathers seven data bits per byte, checks the length limit and undoes the
// zigzag mapping when a value ends.
// ----------------------------------------------------------------------------
module zvd_decode import zvd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  beat_t    beat_i,
  output dec_out_t dec_o
);

  logic [ValueW-1:0] acc_q, acc_d;
  logic [CountW-1:0] seen_q, seen_d;
  width_e            held_q, held_d;

  width_e            wc;
  logic [CountW-1:0] last;
  logic [CountW-1:0] pos;
  logic [CountW-1:0] count;
  logic [GroupW-1:0] data;
  logic              cont;
  logic              err;
  logic [ShiftW-1:0] shamt;
  logic [ValueW-1:0] acc_new;
  logic [ValueW-1:0] wmask;
  logic [ValueW-1:0] zz;
  logic [ValueW-1:0] unzz;

  always_comb begin
    wc      = (seen_q == '0) ? width_e'(beat_i.width_code) : held_q;
    last    = last_index(wc);
    pos     = (seen_q > last) ? last : seen_q;
    count   = pos + 4'd1;
    data    = beat_i.data_byte[GroupW-1:0] & DataMask;
    cont    = (beat_i.data_byte & ContMask) != '0;
    err     = (pos == last) && (((data & excess_mask(wc)) != '0) || cont);
    shamt   = {2'b00, pos} * 6'd7;
    acc_new = acc_q | ({57'd0, data} << shamt);
    wmask   = width_mask(wc);
    zz      = acc_new & wmask;
    unzz    = ({1'b0, zz[ValueW-1:1]} ^ {ValueW{zz[0]}}) & wmask;

    dec_o.produce        = err || !cont;
    dec_o.res.value      = err ? '0 : unzz;
    dec_o.res.too_long   = err;
    dec_o.res.byte_count = count;

    acc_d  = acc_q;
    seen_d = seen_q;
    held_d = held_q;
    if (fire_i) begin
      if (err || !cont) begin
        acc_d  = '0;
        seen_d = '0;
        held_d = W8;
      end else begin
        acc_d  = acc_new;
        seen_d = count;
        held_d = wc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      seen_q <= '0;
      held_q <= W8;
    end else begin
      acc_q  <= acc_d;
      seen_q <= seen_d;
      held_q <= held_d;
    end
  end

endmodule

// ----- hw/rtl/zvd_out_reg.sv -----
// ----------------------------------------------------------------------------
// Result register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module zvd_out_reg import zvd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  input  logic    ready_i,
  output logic    advance_o,
  output logic    valid_o,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q, res_d;

  assign advance_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (advance_o) begin
      valid_d = load_i;
      if (load_i) begin
        res_d = res_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ----- hw/rtl/zigzag_varint_decoder_unit.sv -----
// A result is loaded into the result register when the beat of its final byte leaves the input register.
// Throughput: one byte per cycle while the result register is not stalled; the accumulator update in
// the decode stage is combinational, so bytes of one value follow back to back.
// Reset: asynchronous, clears the accumulator, byte count, held width and
// both stage valid flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Zigzag varint decoder, top level
// Input register, decode stage with accumulator state, and result register.
// ----------------------------------------------------------------------------
`include "zigzag_varint_decoder_unit_defines.svh"

module zigzag_varint_decoder_unit import zvd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  zvd_in_if.sink    in_i,
  zvd_out_if.source out_o
);

  beat_t    in_beat;
  beat_t    s1_beat;
  logic     s1_valid;
  logic     advance;
  logic     fire;
  dec_out_t dec;
  result_t  res;
  logic     res_valid;

  assign in_beat.data_byte  = in_i.data_byte;
  assign in_beat.width_code = in_i.width_code;

  zvd_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_i.valid),
    .ready_o   (in_i.ready),
    .beat_i    (in_beat),
    .advance_i (advance),
    .valid_o   (s1_valid),
    .beat_o    (s1_beat)
  );

  assign fire = s1_valid && advance;

  zvd_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .beat_i (s1_beat),
    .dec_o  (dec)
  );

  zvd_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (fire && dec.produce),
    .res_i     (dec.res),
    .ready_i   (out_o.ready),
    .advance_o (advance),
    .valid_o   (res_valid),
    .res_o     (res)
  );

  assign out_o.valid      = res_valid;
  assign out_o.value      = res.value;
  assign out_o.too_long   = res.too_long;
  assign out_o.byte_count = res.byte_count;

  `ZVD_ASSERT(a_err_value_zero, (res_valid && res.too_long) |-> (res.value == '0), "error beat with nonzero value")
  `ZVD_ASSERT_NEVER(a_count_range, res_valid && ((res.byte_count == 4'd0) || (res.byte_count > 4'd10)), "byte count out of range")
  `ZVD_ASSERT(a_stage_hold, (s1_valid && !advance) |=> (s1_valid && $stable(s1_beat)), "input stage lost a stalled beat")

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// Testbench for the zigzag varint decoder
// Sends encoded bytes over the input channel with random gaps and predicts
// every decoded value or too-long error in a scoreboard. Each result beat is
// checked field by field, in order, against the oldest prediction. The run
// covers all widths, the byte limits and a long hold-off on the output.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import zvd_pkg::*;

  localparam int unsigned RandomBeats = 1100;
  localparam int unsigned IdleLimit   = 3000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned HoldAfter   = 150;

  class varint_scoreboard;
    result_t           expected_results[$];
    logic [ValueW-1:0] acc;
    logic [CountW-1:0] bytes_taken;
    width_e            held_wc;
    int unsigned       errors;

    function new();
      clear_value();
      errors = 0;
    endfunction

    static function logic [CountW-1:0] last_pos(width_e w);
      case (w)
        W8:      return 4'd1;
        W16:     return 4'd2;
        W32:     return 4'd4;
        default: return 4'd9;
      endcase
    endfunction

    static function logic [GroupW-1:0] forbidden_bits(width_e w);
      case (w)
        W8:      return 7'h7E;
        W16:     return 7'h7C;
        W32:     return 7'h70;
        default: return 7'h7E;
      endcase
    endfunction

    static function logic [ValueW-1:0] keep_mask(width_e w);
      case (w)
        W8:      return 64'hFF;
        W16:     return 64'hFFFF;
        W32:     return 64'hFFFF_FFFF;
        default: return {ValueW{1'b1}};
      endcase
    endfunction

    function void clear_value();
      acc         = '0;
      bytes_taken = '0;
      held_wc     = W8;
    endfunction

    function void note_beat(logic [ByteW-1:0] b, logic [WcodeW-1:0] wc_in);
      logic [GroupW-1:0] grp;
      logic              cont;
      logic [CountW-1:0] pos;
      logic [ValueW-1:0] zz;
      result_t           r;
      grp  = b[GroupW-1:0] & DataMask;
      cont = (b & ContMask) != '0;
      if (bytes_taken == 0) held_wc = width_e'(wc_in);
      pos = bytes_taken;
      if (pos > last_pos(held_wc)) pos = last_pos(held_wc);
      if (pos == last_pos(held_wc) && (((grp & forbidden_bits(held_wc)) != '0) || cont)) begin
        r.value      = '0;
        r.too_long   = 1'b1;
        r.byte_count = pos + 4'd1;
        expected_results.push_back(r);
        clear_value();
        return;
      end
      acc |= {{(ValueW-GroupW){1'b0}}, grp} << (GroupW * pos);
      if (cont) begin
        bytes_taken = pos + 4'd1;
        return;
      end
      zz           = acc & keep_mask(held_wc);
      r.value      = ((zz >> 1) ^ {ValueW{zz[0]}}) & keep_mask(held_wc);
      r.too_long   = 1'b0;
      r.byte_count = pos + 4'd1;
      expected_results.push_back(r);
      clear_value();
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (expected_results.size() == 0) begin
        $error("unexpected result: value %h too_long %0d byte_count %0d",
               got.value, got.too_long, got.byte_count);
        errors++;
        return;
      end
      exp = expected_results.pop_front();
      if (got.value !== exp.value) begin
        $error("value: expected %h, actual %h", exp.value, got.value);
        errors++;
      end
      if (got.too_long !== exp.too_long) begin
        $error("too_long: expected %0d, actual %0d", exp.too_long, got.too_long);
        errors++;
      end
      if (got.byte_count !== exp.byte_count) begin
        $error("byte_count: expected %0d, actual %0d", exp.byte_count, got.byte_count);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  zvd_in_if  in_if ();
  zvd_out_if out_if ();

  zigzag_varint_decoder_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  varint_scoreboard sb;
  int unsigned      beats_sent;
  int unsigned      tx_burst;
  int unsigned      rx_burst;
  int unsigned      idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap(inout int unsigned burst);
    int unsigned r;
    if (burst != 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [GroupW-1:0] rand_group();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return DataMask;
    return GroupW'($urandom_range(0, 127));
  endfunction

  task automatic send_beat(input logic [ByteW-1:0] b, input width_e w);
    int unsigned gap;
    in_if.valid      <= 1'b1;
    in_if.data_byte  <= b;
    in_if.width_code <= w;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_beat(b, w);
    beats_sent++;
    gap = pick_gap(tx_burst);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // The width code is random on every byte after the first of a value.
  task automatic send_varint(input width_e w, input int unsigned len, input bit cont_last,
                             input bit allow_excess);
    logic [GroupW-1:0] grp;
    logic              cont;
    width_e            wc;
    for (int unsigned i = 0; i < len; i++) begin
      grp  = rand_group();
      cont = (i == len - 1) ? cont_last : 1'b1;
      if (i == len - 1 && i == varint_scoreboard::last_pos(w) && !allow_excess) begin
        grp &= ~varint_scoreboard::forbidden_bits(w);
      end
      wc = (i == 0) ? w : width_e'($urandom_range(0, 3));
      send_beat({cont, grp}, wc);
    end
  endtask

  initial begin
    int unsigned r;
    int unsigned lp;
    width_e      w;
    sb          = new();
    beats_sent  = 0;
    tx_burst    = 0;
    in_if.valid      <= 1'b0;
    in_if.data_byte  <= '0;
    in_if.width_code <= W8;
    rst_ni           <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(8'h00, W8);
    send_beat(8'h01, W8);
    send_beat(8'hFF, W8);
    send_beat(8'h01, W8);
    // Excess data bits at the last byte of an 8-bit value.
    send_beat(8'h80, W8);
    send_beat(8'h02, W8);
    // Continuation bit set at the last byte of an 8-bit value.
    send_beat(8'h80, W8);
    send_beat(8'h81, W8);
    // The width code changes in the middle of a 16-bit value.
    send_beat(8'hFF, W16);
    send_beat(8'hFF, W8);
    send_beat(8'h03, W64);
    send_beat(8'h80, W32);
    repeat (3) send_beat(8'h80, W32);
    send_beat(8'h10, W32);
    repeat (9) send_beat(8'hFF, W64);
    send_beat(8'h01, W64);

    while (beats_sent < RandomBeats) begin
      r  = $urandom_range(0, 99);
      w  = width_e'($urandom_range(0, 3));
      lp = varint_scoreboard::last_pos(w);
      if (r < 75) begin
        send_varint(w, $urandom_range(1, lp + 1), 1'b0, $urandom_range(0, 7) == 0);
      end else if (r < 85) begin
        send_varint(w, lp + 1, 1'b1, 1'b1);
      end else if (r < 92) begin
        send_varint(w, lp + 1, 1'b0, 1'b1);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_beat(ByteW'($urandom_range(0, 255)), width_e'($urandom_range(0, 3)));
        end
      end
    end
    in_if.valid <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    int unsigned hold;
    int unsigned results_seen;
    bit          held;
    result_t     got;
    stall        = 0;
    hold         = 0;
    results_seen = 0;
    held         = 1'b0;
    rx_burst     = 0;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        got.value      = out_if.value;
        got.too_long   = out_if.too_long;
        got.byte_count = out_if.byte_count;
        sb.check_result(got);
        results_seen++;
      end
      if (!held && results_seen >= HoldAfter) begin
        held = 1'b1;
        hold = HoldCycles;
      end
      if (hold != 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else if (stall != 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        stall = pick_gap(rx_burst);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule
